// ----- rtl/ftsp_pkg.sv -----
package ftsp_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned DIV_BITS    = 13;
  localparam int unsigned HOLD_BITS   = 21;
  localparam int unsigned STEP_BITS   = 6;

  localparam logic REQ_TUNE           = 1'b0;
  localparam logic REQ_VOLUME         = 1'b1;

  localparam logic [22:0] IF_OFFSET   = 23'd171200;
  localparam logic [22:0] FREQ_MUL    = 23'd125;
  // x / 800 = (x >> 5) / 25; 5242 / 2^17 slightly under 1/25, one correction step
  localparam int unsigned PRE_SHIFT   = 5;
  localparam logic [29:0] RECIP_MUL   = 30'd5242;
  localparam int unsigned RECIP_SHIFT = 17;
  localparam logic [17:0] DIV_ODD     = 18'd25;

  localparam logic [21:0] VOL_UNIT    = 22'd10000;
  localparam logic [20:0] BIT_DELAY   = 21'd1000;

  localparam logic [7:0] BYTE_OFF     = 8'hD0;
  localparam logic [7:0] BYTE_ON      = 8'hD8;
  localparam logic [7:0] BYTE_VOL_UP  = 8'h98;
  localparam logic [7:0] BYTE_VOL_DN  = 8'h58;
  localparam logic [3:0] SER_HIGH     = 4'hD;

  localparam logic [STEP_BITS-1:0] TUNE_LAST_STEP = 6'd50;

  typedef enum logic [1:0] {
    CMD_TUNE,
    CMD_OFF,
    CMD_VOL_UP,
    CMD_VOL_DN
  } cmd_kind_t;

  typedef struct packed {
    logic              req_type;
    logic [15:0]       freq;
    logic signed [7:0] vol_steps;
  } in_req_t;

  typedef struct packed {
    logic [7:0]  port_value;
    logic [20:0] hold_time;
    logic        last;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [DIV_BITS-1:0]    div;
    logic [HOLD_BITS-1:0]   hold;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- rtl/ftsp_front.sv -----
module ftsp_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ftsp_pkg::in_req_t in_data,
  input  logic             q_full,
  output logic             push,
  output ftsp_pkg::cmd_t   push_cmd
);

  logic                 en;
  logic [22:0]          prod125;
  logic [22:0]          scaled;
  logic [7:0]           vol_mag;
  logic [21:0]          vol_hold;
  ftsp_pkg::cmd_kind_t  kind_in;
  logic                 keep_in;

  logic                 a_v_r;
  ftsp_pkg::cmd_kind_t  a_kind_r;
  logic [17:0]          a_y_r;
  logic [20:0]          a_hold_r;

  logic [29:0]          recip_prod;
  logic                 b_v_r;
  ftsp_pkg::cmd_kind_t  b_kind_r;
  logic [17:0]          b_y_r;
  logic [12:0]          b_q_r;
  logic [20:0]          b_hold_r;

  logic [17:0]          rem;
  logic [12:0]          div_fix;

  assign en       = !b_v_r || !q_full;
  assign in_ready = en;

  always_comb begin
    prod125  = 23'(in_data.freq) * ftsp_pkg::FREQ_MUL;
    scaled   = (prod125 >> 1) + ftsp_pkg::IF_OFFSET;
    vol_mag  = in_data.vol_steps[7] ? 8'(~in_data.vol_steps + 8'sd1)
                                    : 8'(in_data.vol_steps);
    vol_hold = 22'(vol_mag) * ftsp_pkg::VOL_UNIT;
    keep_in  = 1'b1;
    if (in_data.req_type == ftsp_pkg::REQ_TUNE) begin
      kind_in = (in_data.freq == 16'd0) ? ftsp_pkg::CMD_OFF : ftsp_pkg::CMD_TUNE;
    end else begin
      kind_in = in_data.vol_steps[7] ? ftsp_pkg::CMD_VOL_DN : ftsp_pkg::CMD_VOL_UP;
      keep_in = (in_data.vol_steps != 8'sd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid && keep_in;
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_kind_r <= kind_in;
      a_y_r    <= scaled[22:ftsp_pkg::PRE_SHIFT];
      a_hold_r <= vol_hold[20:0];
      b_kind_r <= a_kind_r;
      b_y_r    <= a_y_r;
      b_q_r    <= recip_prod[ftsp_pkg::RECIP_SHIFT +: 13];
      b_hold_r <= a_hold_r;
    end
  end

  assign recip_prod = 30'(a_y_r) * ftsp_pkg::RECIP_MUL;

  always_comb begin
    rem     = b_y_r - (18'(b_q_r) * ftsp_pkg::DIV_ODD);
    div_fix = (rem >= ftsp_pkg::DIV_ODD) ? b_q_r + 13'd1 : b_q_r;
  end

  assign push          = b_v_r && !q_full;
  assign push_cmd.kind = b_kind_r;
  assign push_cmd.div  = div_fix;
  assign push_cmd.hold = b_hold_r;

endmodule

// ----- rtl/ftsp_queue.sv -----
module ftsp_queue #(
  parameter int unsigned DEPTH = ftsp_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ftsp_pkg::cmd_t       push_cmd,
  input  logic                 pop,
  output ftsp_pkg::cmd_t       head,
  output ftsp_pkg::q_status_t  status
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ftsp_pkg::cmd_t mem [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r,  count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  assign head         = mem[rd_ptr_r];
  assign status.full  = (count_r == CW'(DEPTH));
  assign status.empty = (count_r == '0);

endmodule

// ----- rtl/ftsp_back.sv -----
module ftsp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                audio_on,
  input  ftsp_pkg::cmd_t      head,
  input  logic                q_empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output ftsp_pkg::out_item_t out_data
);

  logic [ftsp_pkg::STEP_BITS-1:0] step_r, step_nxt;
  logic                           out_valid_r, out_valid_nxt;
  ftsp_pkg::out_item_t            out_r;
  ftsp_pkg::out_item_t            item;
  logic [24:0]                    word;
  logic                           ser_bit;
  logic                           ld;

  assign ld = !q_empty && (!out_valid_r || out_ready);

  always_comb begin
    word    = {1'b1, 1'b0, 1'b1, 7'b0, head.div, 2'b00};
    ser_bit = word[step_r[5:1]];
    item    = '0;
    case (head.kind)
      ftsp_pkg::CMD_TUNE: begin
        if (step_r == ftsp_pkg::TUNE_LAST_STEP) begin
          item.port_value = audio_on ? ftsp_pkg::BYTE_ON : ftsp_pkg::BYTE_OFF;
          item.last       = 1'b1;
        end else begin
          item.port_value = {ftsp_pkg::SER_HIGH, audio_on, ser_bit, step_r[0], 1'b1};
          item.hold_time  = ftsp_pkg::BIT_DELAY;
        end
      end
      ftsp_pkg::CMD_OFF: begin
        item.port_value = ftsp_pkg::BYTE_OFF;
        item.last       = 1'b1;
      end
      ftsp_pkg::CMD_VOL_UP, ftsp_pkg::CMD_VOL_DN: begin
        if (step_r == '0) begin
          item.port_value = (head.kind == ftsp_pkg::CMD_VOL_UP) ? ftsp_pkg::BYTE_VOL_UP
                                                               : ftsp_pkg::BYTE_VOL_DN;
          item.hold_time  = head.hold;
        end else begin
          item.port_value = ftsp_pkg::BYTE_ON;
          item.last       = 1'b1;
        end
      end
      default: begin
        item.port_value = ftsp_pkg::BYTE_OFF;
        item.last       = 1'b1;
      end
    endcase

    pop           = ld && item.last;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (ld) begin
      step_nxt      = item.last ? '0 : step_r + 1'b1;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_r <= item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/fm_tuner_serial_program.sv -----
// Tuner control-port sequencer. Each request becomes the run of port writes
// for the card: a nonzero tune gives 51 writes (25 serial bits, clock low and
// high, then the closing byte), a zero frequency one write, a volume step two
// writes and a zero volume step none. The back end issues at most one write per
// cycle, holding a write while out_ready is low; requests are taken into the
// divider pipeline (a and b registers) and a short command queue while
// earlier writes are still going out. cfg_wr_data is the audio-on flag,
// sampled as writes are produced.
module fm_tuner_serial_program #(
  parameter int unsigned QUEUE_DEPTH = ftsp_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ftsp_pkg::in_req_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ftsp_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data
);

  logic                audio_on_r;
  logic                push;
  logic                pop;
  ftsp_pkg::cmd_t      push_cmd;
  ftsp_pkg::cmd_t      head;
  ftsp_pkg::q_status_t q_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      audio_on_r <= 1'b1;
    end else if (cfg_wr_en) begin
      audio_on_r <= cfg_wr_data;
    end
  end

  ftsp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_status.full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  ftsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  ftsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .audio_on  (audio_on_r),
    .head      (head),
    .q_empty   (q_status.empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_last_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> out_data.hold_time == 21'd0)
    else $error("final write carries a hold time");

  a_mid_has_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> out_data.hold_time != 21'd0)
    else $error("intermediate write without hold time");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("command queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_status.full)
    else $error("command queue pushed while full");

endmodule

// ----- sim/fm_tuner_port_checker.sv -----
`timescale 1ns / 1ps

module fm_tuner_port_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  ftsp_pkg::in_req_t   in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  ftsp_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  output int unsigned         n_errors,
  output int unsigned         n_pending
);

  // fixed serial tail: test, band, time base, spacing, FM (sent lsb first)
  localparam logic [9:0] SER_TAIL = 10'b10_1000_0000;

  logic                audio_on;
  ftsp_pkg::out_item_t port_writes_q[$];
  int unsigned         err_cnt = 0;

  task automatic add_write(input logic [7:0] value, input logic [20:0] hold, input logic fin);
    ftsp_pkg::out_item_t w;
    w.port_value = value;
    w.hold_time  = hold;
    w.last       = fin;
    port_writes_q.push_back(w);
  endtask

  task automatic plan_port_writes(input ftsp_pkg::in_req_t r);
    logic [31:0] scaled;
    logic [12:0] div;
    logic [24:0] frame;
    logic [7:0]  ser;
    logic [7:0]  mag;
    logic [20:0] pulse;
    if (r.req_type == ftsp_pkg::REQ_TUNE) begin
      if (r.freq == 16'd0) begin
        add_write(ftsp_pkg::BYTE_OFF, 21'd0, 1'b1);
      end else begin
        scaled = ((32'(r.freq) * 32'(ftsp_pkg::FREQ_MUL)) >> 1) + 32'(ftsp_pkg::IF_OFFSET);
        div    = 13'(scaled / 32'd800);
        frame  = {SER_TAIL, div, 2'b00};
        for (int i = 0; i < 25; i++) begin
          ser = {ftsp_pkg::SER_HIGH, audio_on, frame[i], 1'b0, 1'b1};
          add_write(ser, ftsp_pkg::BIT_DELAY, 1'b0);
          add_write(ser | 8'h02, ftsp_pkg::BIT_DELAY, 1'b0);
        end
        add_write(audio_on ? ftsp_pkg::BYTE_ON : ftsp_pkg::BYTE_OFF, 21'd0, 1'b1);
      end
    end else if (r.vol_steps != 8'sd0) begin
      mag   = r.vol_steps[7] ? 8'(-r.vol_steps) : 8'(r.vol_steps);
      pulse = 21'(32'(mag) * 32'(ftsp_pkg::VOL_UNIT));
      add_write(r.vol_steps[7] ? ftsp_pkg::BYTE_VOL_DN : ftsp_pkg::BYTE_VOL_UP, pulse, 1'b0);
      add_write(ftsp_pkg::BYTE_ON, 21'd0, 1'b1);
    end
  endtask

  always @(posedge clk) begin : watch
    ftsp_pkg::out_item_t want;
    if (!rst_n) begin
      audio_on = 1'b1;
      port_writes_q.delete();
    end else begin
      if (cfg_wr_en) begin
        audio_on = cfg_wr_data;
      end
      if (out_valid && out_ready) begin
        if (port_writes_q.size() == 0) begin
          $error("port write %0h with none expected", out_data.port_value);
          err_cnt++;
        end else begin
          want = port_writes_q.pop_front();
          if (out_data.port_value !== want.port_value) begin
            $error("port_value expected %0h got %0h", want.port_value, out_data.port_value);
            err_cnt++;
          end
          if (out_data.hold_time !== want.hold_time) begin
            $error("hold_time expected %0d got %0d", want.hold_time, out_data.hold_time);
            err_cnt++;
          end
          if (out_data.last !== want.last) begin
            $error("last expected %0b got %0b", want.last, out_data.last);
            err_cnt++;
          end
        end
      end
      if (in_valid && in_ready) begin
        plan_port_writes(in_data);
      end
    end
    n_errors  <= err_cnt;
    n_pending <= port_writes_q.size();
  end

endmodule

// ----- sim/tb_fm_tuner_serial_program.sv -----
`timescale 1ns / 1ps

module tb_fm_tuner_serial_program;

  localparam int unsigned PHASES          = 6;
  localparam int unsigned ITEMS_PER_PHASE = 60;
  localparam int unsigned DRAIN_CYCLES    = 12;
  localparam int unsigned HOLD_CYCLES     = 600;
  localparam int unsigned HOLD_AT_REQUEST = 150;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  ftsp_pkg::in_req_t   in_data     = '0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  ftsp_pkg::out_item_t out_data;
  logic                cfg_wr_en   = 1'b0;
  logic                cfg_wr_data = 1'b1;
  int unsigned         n_errors;
  int unsigned         n_pending;
  int unsigned         sent        = 0;
  int unsigned         writes_seen = 0;

  always #2 clk = ~clk;

  fm_tuner_serial_program dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  fm_tuner_port_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .n_errors    (n_errors),
    .n_pending   (n_pending)
  );

  task automatic send_request(input logic kind, input logic [15:0] f, input logic [7:0] st);
    ftsp_pkg::in_req_t r;
    int unsigned gap;
    r.req_type  = kind;
    r.freq      = f;
    r.vol_steps = st;
    gap = (sent % 50 < 15) ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!(in_valid && in_ready));
    sent++;
  endtask

  task automatic send_random();
    int unsigned pick;
    logic [15:0] f;
    logic [7:0]  st;
    pick = $urandom_range(0, 99);
    f    = 16'($urandom_range(0, 65535));
    st   = 8'($urandom_range(0, 255));
    if (pick < 6) begin
      send_request(ftsp_pkg::REQ_TUNE, 16'h0000, st);
    end else if (pick < 10) begin
      send_request(ftsp_pkg::REQ_TUNE, pick[0] ? 16'hFFFF : 16'h0001, st);
    end else if (pick < 45) begin
      send_request(ftsp_pkg::REQ_TUNE, f, st);
    end else if (pick < 50) begin
      send_request(ftsp_pkg::REQ_VOLUME, f, 8'h00);
    end else begin
      send_request(ftsp_pkg::REQ_VOLUME, f, (st == 8'h00) ? 8'h01 : st);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_audio(input logic on);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= on;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin : port_side
    int unsigned gap;
    bit          held;
    held = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && sent >= HOLD_AT_REQUEST) begin
        // long back-pressure while requests keep coming
        held = 1'b1;
        gap  = HOLD_CYCLES;
      end else if ((writes_seen / 120) % 4 == 1) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 11);
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      writes_seen++;
    end
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(ftsp_pkg::REQ_TUNE,   16'h0000, 8'h00);
    send_request(ftsp_pkg::REQ_TUNE,   16'h0001, 8'hFF);
    send_request(ftsp_pkg::REQ_TUNE,   16'hFFFF, 8'h00);
    send_request(ftsp_pkg::REQ_TUNE,   16'h5555, 8'h80);
    send_request(ftsp_pkg::REQ_TUNE,   16'hAAAA, 8'h7F);
    send_request(ftsp_pkg::REQ_VOLUME, 16'hFFFF, 8'h00);
    send_request(ftsp_pkg::REQ_VOLUME, 16'h0000, 8'h01);
    send_request(ftsp_pkg::REQ_VOLUME, 16'h0000, 8'hFF);
    send_request(ftsp_pkg::REQ_VOLUME, 16'h0000, 8'h7F);
    send_request(ftsp_pkg::REQ_VOLUME, 16'hAAAA, 8'h80);
    send_request(ftsp_pkg::REQ_VOLUME, 16'h5555, 8'h55);
    send_request(ftsp_pkg::REQ_VOLUME, 16'h0000, 8'hAA);

    set_audio(1'b0);
    send_request(ftsp_pkg::REQ_TUNE,   16'h0000, 8'h00);
    send_request(ftsp_pkg::REQ_TUNE,   16'hFFFF, 8'h00);
    send_request(ftsp_pkg::REQ_TUNE,   16'h1234, 8'h00);
    send_request(ftsp_pkg::REQ_VOLUME, 16'h0000, 8'h05);
    send_request(ftsp_pkg::REQ_VOLUME, 16'h0000, 8'hFB);

    set_audio(1'b1);
    send_request(ftsp_pkg::REQ_TUNE,   16'h0000, 8'h00);

    for (int p = 0; p < PHASES; p++) begin
      set_audio((p < 2) ? p[0] : 1'($urandom_range(0, 1)));
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        send_random();
      end
    end

    wait_idle();
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
